// File: sv/mfsc_pkg.sv
// Shared types, constants and checksum step for the frame sequence/CRC appender.
package mfsc_pkg;

  localparam int unsigned SEQ_POS_DEFAULT = 4;
  localparam int unsigned POS_W           = 9;
  localparam logic [POS_W-1:0] POS_MAX    = '1;

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [7:0]  EXTRA_SEED_RST  = 8'd50;
  localparam logic        SEQ_ENABLE_RST  = 1'b1;

  localparam int unsigned CFG_IDX_W       = 1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRA_SEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_ENABLE = 1'd1;

  // Output queue: four beats, room for one full frame end plus one beat.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_IDX_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  // Beats caused by one input byte; beat 0 goes out first.
  typedef struct packed {
    beat_t [2:0] beats;
    logic  [1:0] count;
  } result_t;

  // One byte of CRC-16/MCRF4XX (reflected X.25 polynomial).
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

// File: sv/mfsc_core.sv
// Per-frame state: byte position, frame counter, running checksum; forms the beats.
module mfsc_core #(
  parameter int unsigned SEQ_BYTE_POSITION = mfsc_pkg::SEQ_POS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  input  logic [7:0]            extra_seed,
  input  logic                  seq_enable,
  output mfsc_pkg::result_t     res
);

  logic [mfsc_pkg::POS_W-1:0] pos, pos_next;
  logic [7:0]                 fcnt, fcnt_next;
  logic [15:0]                crc, crc_next;

  logic [7:0]  b;
  logic [15:0] crc_body;
  logic [15:0] crc_final;

  always_comb begin
    b = (seq_enable && pos == mfsc_pkg::POS_W'(SEQ_BYTE_POSITION)) ? fcnt : in_byte;
    // start byte stays out of the checksum
    crc_body  = (pos != '0) ? mfsc_pkg::crc_fold(crc, b) : crc;
    crc_final = mfsc_pkg::crc_fold(crc_body, extra_seed);

    res.beats[0] = '{data: b,               last: 1'b0};
    res.beats[1] = '{data: crc_final[7:0],  last: 1'b0};
    res.beats[2] = '{data: crc_final[15:8], last: 1'b1};
    res.count    = in_last ? 2'd3 : 2'd1;

    pos_next  = pos;
    fcnt_next = fcnt;
    crc_next  = crc;
    if (accept) begin
      if (in_last) begin
        pos_next  = '0;
        fcnt_next = fcnt + 8'd1;
        crc_next  = mfsc_pkg::CRC_INIT;
      end else begin
        crc_next = crc_body;
        if (pos != mfsc_pkg::POS_MAX) pos_next = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      fcnt <= '0;
      crc  <= mfsc_pkg::CRC_INIT;
    end else begin
      pos  <= pos_next;
      fcnt <= fcnt_next;
      crc  <= crc_next;
    end
  end

  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> pos == '0 && crc == mfsc_pkg::CRC_INIT)
    else $error("frame end did not restart position and checksum");

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    accept && !in_last && pos != mfsc_pkg::POS_MAX |=> pos == $past(pos) + 1'b1)
    else $error("byte position did not advance");

  a_fcnt_step: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> fcnt == $past(fcnt) + 8'd1)
    else $error("frame counter did not step at frame end");

endmodule

// File: sv/mfsc_outq.sv
// Four-entry output beat queue; takes one or three beats per push, gives one per pop.
module mfsc_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  mfsc_pkg::result_t             res,
  input  logic                          pop,
  output logic                          room,
  output logic                          head_valid,
  output mfsc_pkg::beat_t               head,
  output logic [mfsc_pkg::Q_CNT_W-1:0]  fill
);

  mfsc_pkg::beat_t mem [mfsc_pkg::Q_DEPTH];

  logic [mfsc_pkg::Q_IDX_W-1:0] wptr, wptr_next;
  logic [mfsc_pkg::Q_IDX_W-1:0] rptr, rptr_next;
  logic [mfsc_pkg::Q_CNT_W-1:0] cnt, cnt_next;
  logic [1:0]                   push_n;

  always_comb begin
    push_n    = push ? res.count : 2'd0;
    wptr_next = wptr + push_n;
    rptr_next = rptr + mfsc_pkg::Q_IDX_W'(pop);
    cnt_next  = cnt + mfsc_pkg::Q_CNT_W'(push_n) - mfsc_pkg::Q_CNT_W'(pop);
  end

  // room for a full frame end
  assign room       = cnt <= mfsc_pkg::Q_CNT_W'(1);
  assign head_valid = cnt != '0;
  assign head       = mem[rptr];
  assign fill       = cnt;

  always_ff @(posedge clk) begin
    for (int i = 0; i < mfsc_pkg::Q_DEPTH; i++) begin
      logic [mfsc_pkg::Q_IDX_W-1:0] off;
      off = mfsc_pkg::Q_IDX_W'(i) - wptr;
      if (push && off < push_n) mem[i] <= res.beats[off];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      wptr <= wptr_next;
      rptr <= rptr_next;
      cnt  <= cnt_next;
    end
  end

endmodule

// File: sv/mavlink2_frame_seq_crc_appender.sv
// Top level: frame sequence stamping and CRC-16/MCRF4XX appending on a byte stream.
// An accepted input beat is written into the output queue and leaves after the beats ahead of it.
// Throughput: one byte per cycle inside a frame while out_stall is low; the last
//   byte adds two checksum beats that stall the input (four-beat output queue).
// Reset (rst, synchronous): checksum 0xFFFF, position 0, frame counter 0,
//   extra_seed 50, seq_enable 1, output queue empty.
module mavlink2_frame_seq_crc_appender #(
  parameter int unsigned SEQ_BYTE_POSITION = mfsc_pkg::SEQ_POS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [mfsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data,
  // input byte channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte,
  input  logic                            in_last,
  // output byte channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            out_last
);

  logic [7:0] extra_seed;
  logic       seq_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      extra_seed <= mfsc_pkg::EXTRA_SEED_RST;
      seq_enable <= mfsc_pkg::SEQ_ENABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mfsc_pkg::REG_EXTRA_SEED: extra_seed <= cfg_data;
        mfsc_pkg::REG_SEQ_ENABLE: seq_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic                          room;
  logic                          accept;
  logic                          pop;
  mfsc_pkg::result_t             res;
  mfsc_pkg::beat_t               head;
  logic [mfsc_pkg::Q_CNT_W-1:0]  fill;

  // stall comes from queue occupancy alone, so it is registered state
  assign in_stall = !room;
  assign accept   = in_valid && room;
  assign pop      = out_valid && !out_stall;

  mfsc_core #(
    .SEQ_BYTE_POSITION(SEQ_BYTE_POSITION)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .extra_seed (extra_seed),
    .seq_enable (seq_enable),
    .res        (res)
  );

  mfsc_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .res        (res),
    .pop        (pop),
    .room       (room),
    .head_valid (out_valid),
    .head       (head),
    .fill       (fill)
  );

  assign out_byte = head.data;
  assign out_last = head.last;

  // a frame end leaves at least two beats queued (three pushed, at most one popped)
  a_frame_end_fill: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> fill >= mfsc_pkg::Q_CNT_W'(2))
    else $error("checksum beats missing from queue");

  // occupancy never exceeds queue depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= mfsc_pkg::Q_CNT_W'(mfsc_pkg::Q_DEPTH))
    else $error("output queue overflow");

  // after an accepted beat the output is valid next cycle
  a_accept_visible: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat not queued");

endmodule
